// File: sv/hjb_pkg.sv
// ----------------------------------------------------------------------------
// hjb_pkg
// Shared item types and codes for the hash join build/probe table.
// ----------------------------------------------------------------------------
`default_nettype none

package hjb_pkg;

    // field widths fixed by the item format
    localparam int KEY_W = 32;
    localparam int HND_W = 16;

    // opcodes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_MATCH    = 2'd2;
    localparam logic [1:0] ST_NOMATCH  = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
        logic [HND_W-1:0] row_handle;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] match_key;
        logic [HND_W-1:0] build_handle;
        logic [HND_W-1:0] probe_handle;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/hjb_hash.sv
// ----------------------------------------------------------------------------
// hjb_hash
// Three-stage bucket index pipeline: key mod NUM_BUCKETS by reciprocal
// multiply, back-multiply and a single correcting subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module hjb_hash
    import hjb_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  t_in_item                        i_item,
    output logic                            o_valid,
    input  wire                             i_ready,
    output t_in_item                        o_item,
    output logic [$clog2(NUM_BUCKETS)-1:0]  o_bkt
);

    localparam int          BKT_W   = $clog2(NUM_BUCKETS);
    localparam int          SHIFT   = KEY_W + BKT_W;
    localparam logic [63:0] RECIP_L = (64'd1 << SHIFT) / 64'(NUM_BUCKETS);
    localparam logic [32:0] RECIP   = RECIP_L[32:0];
    localparam logic [31:0] NB      = 32'(NUM_BUCKETS);

    logic                  r_v1, r_v2, r_v3;
    t_in_item              r_item1, r_item2, r_item3;
    logic [64:0]           r_prod1;
    logic [KEY_W-1:0]      r_qn2;
    logic [BKT_W-1:0]      r_bkt3;
    logic                  adv1, adv2, adv3;
    logic [KEY_W-1:0]      quot;
    logic [KEY_W-1:0]      rem;
    logic [KEY_W-1:0]      rem_c;

    // stage enables, a stage loads when empty or when it drains
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // quotient estimate, at most one below the true quotient
    assign quot = 32'(r_prod1 >> SHIFT);

    // remainder stays below twice the bucket count before correction
    assign rem   = r_item2.key - r_qn2;
    assign rem_c = (rem >= NB) ? (rem - NB) : rem;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_item1 <= i_item;
            r_prod1 <= 65'(i_item.key) * 65'(RECIP);
        end
        if (adv2) begin
            r_item2 <= r_item1;
            r_qn2   <= quot * NB;
        end
        if (adv3) begin
            r_item3 <= r_item2;
            r_bkt3  <= rem_c[BKT_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;
    assign o_bkt   = r_bkt3;

endmodule

`default_nettype wire

// File: sv/hjb_table.sv
// ----------------------------------------------------------------------------
// hjb_table
// Bucket table engine: fill-count memory and bucket-row memory, read on
// accept, compare across the row, write back, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module hjb_table
    import hjb_pkg::*;
#(
    parameter int NUM_BUCKETS  = 1024,
    parameter int BUCKET_DEPTH = 4,
    parameter int HANDLE_BITS  = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  t_in_item                        i_item,
    input  wire [$clog2(NUM_BUCKETS)-1:0]   i_bkt,
    output logic                            o_valid,
    input  wire                             i_ready,
    output t_out_item                       o_item
);

    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int HW     = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HW-1:0]    hnd;
    } t_entry;

    typedef t_entry [BUCKET_DEPTH-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    // memories
    logic [FILL_W-1:0] mem_fill [NUM_BUCKETS];
    t_row              mem_row  [NUM_BUCKETS];

    t_state            r_state, n_state;
    logic [BKT_W-1:0]  r_clr_idx;
    t_in_item          r_item;
    logic [BKT_W-1:0]  r_bkt;
    logic [FILL_W-1:0] r_fill;
    t_row              r_row;
    logic              r_out_vld;
    t_out_item         r_out;

    logic              accept;
    logic              commit;
    logic              is_full;
    logic              do_insert;
    logic              fill_we;
    logic [BKT_W-1:0]  fill_wa;
    logic [FILL_W-1:0] fill_wd;
    t_row              n_row;
    t_entry            new_ent;
    logic              found;
    logic [HW-1:0]     found_h;
    logic [HW-1:0]     hnd_t;
    t_out_item         n_out;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign commit  = (r_state == S_LOOK) && (!r_out_vld || i_ready);

    assign hnd_t     = r_item.row_handle[HW-1:0];
    assign is_full   = (r_fill == FILL_W'(BUCKET_DEPTH));
    assign do_insert = commit && (r_item.opcode == OP_BUILD) && !is_full;

    // fill write port: clearing pass or insert
    always_comb begin
        fill_we = 1'b0;
        fill_wa = r_bkt;
        fill_wd = r_fill + FILL_W'(1);
        if (r_state == S_CLEAR) begin
            fill_we = 1'b1;
            fill_wa = r_clr_idx;
            fill_wd = '0;
        end else if (do_insert) begin
            fill_we = 1'b1;
        end
    end

    // row update: new entry lands in the first free slot
    always_comb begin
        new_ent.key = r_item.key;
        new_ent.hnd = hnd_t;
        n_row       = r_row;
        for (int i = 0; i < BUCKET_DEPTH; i++) begin
            if (FILL_W'(i) == r_fill) begin
                n_row[i] = new_ent;
            end
        end
    end

    // earliest valid entry with an equal key wins
    always_comb begin
        found   = 1'b0;
        found_h = '0;
        for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
            if ((FILL_W'(i) < r_fill) && (r_row[i].key == r_item.key)) begin
                found   = 1'b1;
                found_h = r_row[i].hnd;
            end
        end
    end

    // result formation
    always_comb begin
        n_out.match_key    = r_item.key;
        n_out.build_handle = '0;
        n_out.probe_handle = '0;
        if (r_item.opcode == OP_PROBE) begin
            n_out.probe_handle = HND_W'(hnd_t);
            if (found) begin
                n_out.status       = ST_MATCH;
                n_out.build_handle = HND_W'(found_h);
            end else begin
                n_out.status = ST_NOMATCH;
            end
        end else if (is_full) begin
            n_out.status = ST_FULL;
        end else begin
            n_out.status = ST_INSERTED;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            mem_fill[fill_wa] <= fill_wd;
        end
        if (do_insert) begin
            mem_row[r_bkt] <= n_row;
        end
        if (accept) begin
            r_fill <= mem_fill[i_bkt];
            r_row  <= mem_row[i_bkt];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == BKT_W'(NUM_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + BKT_W'(1);
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_bkt  <= i_bkt;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// File: sv/hash_join_build_probe.sv
// ----------------------------------------------------------------------------
// hash_join_build_probe
// Equi-join hash table with build (insert) and probe (lookup) items.
// ----------------------------------------------------------------------------
// Each item first passes a three-stage pipeline that forms the bucket index
// key mod NUM_BUCKETS, then enters the table engine, which takes no new item
// until the last one has committed: on accept it reads the bucket's fill
// count and entry row from the two table memories, in S_LOOK it compares all
// entries of the row and writes the row back, so an item may hit the bucket
// its predecessor just changed. An item passes the three index stages, the
// table's item register and the result register, which lets the next item in
// while a result waits. After reset the fill counts are swept to zero, one
// bucket per cycle, so the table engine takes no item until every bucket is
// swept; up to three items are accepted into the index pipeline and wait
// there meanwhile. Each item yields one result: inserted, bucket full
// (dropped), probe matched, or probe no match.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_join_build_probe
    import hjb_pkg::*;
#(
    parameter int NUM_BUCKETS  = 1024,
    parameter int BUCKET_DEPTH = 4,
    parameter int HANDLE_BITS  = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_item
);

    localparam int BKT_W = $clog2(NUM_BUCKETS);

    logic              s_bkt_vld;
    logic              s_bkt_rdy;
    t_in_item          s_item;
    logic [BKT_W-1:0]  s_bkt;

    // bucket index pipeline
    hjb_hash #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (s_bkt_vld),
        .i_ready (s_bkt_rdy),
        .o_item  (s_item),
        .o_bkt   (s_bkt)
    );

    // table engine
    hjb_table #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_bkt_vld),
        .o_ready (s_bkt_rdy),
        .i_item  (s_item),
        .i_bkt   (s_bkt),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    // bucket index stays inside the table
    a_bkt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_bkt_vld |-> (32'(s_bkt) < 32'(NUM_BUCKETS)))
        else $error("bucket index out of range");

    // read-modify-write interlock: no back-to-back table item
    a_rmw_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_bkt_vld && s_bkt_rdy) |=> !(s_bkt_vld && s_bkt_rdy))
        else $error("table item accepted during write-back");

    // build results carry no handles
    a_build_hnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_INSERTED
                         || o_out_item.status == ST_FULL))
        |-> (o_out_item.build_handle == '0 && o_out_item.probe_handle == '0))
        else $error("build result with nonzero handle");

    // probe miss carries no build handle
    a_miss_hnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_NOMATCH)
        |-> (o_out_item.build_handle == '0))
        else $error("probe miss with build handle");
`endif

endmodule

`default_nettype wire
